[design/ippg_pkg.sv]
// Shared package for the interlaced plasma pixel generator.
// Holds field widths, register indexes and reset values, the sine table and the
// register structs. It depends on nothing.
`default_nettype none

package ippg_pkg;

   localparam int X_W         = 10;
   localparam int Y_W         = 9;
   localparam int ROW_W       = Y_W - 1;
   localparam int COLOUR_W    = 24;
   localparam int CHAN_W      = 8;
   localparam int STEP_W      = 16;
   localparam int CSR_IDX_W   = 8;
   localparam int SINE_ADDR_W = 9;
   localparam int SINE_W      = 9;
   localparam int PHASE_FRAC  = STEP_W - SINE_ADDR_W;
   localparam int COL_W       = X_W + 1;

   localparam int SCREEN_HEIGHT_DEF = 480;
   localparam int SHIFT_SPAN        = 256;
   localparam int HALF_SPAN         = SHIFT_SPAN / 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_ROW_STEP_A          = 8'd0,
      REG_ROW_STEP_B          = 8'd1,
      REG_COL_STEP_A          = 8'd2,
      REG_COL_STEP_B          = 8'd3,
      REG_FRAME_SHIFT_STEP_A  = 8'd4,
      REG_FRAME_COLOUR_STEP_A = 8'd5,
      REG_FRAME_SHIFT_STEP_B  = 8'd6,
      REG_FRAME_COLOUR_STEP_B = 8'd7
   } reg_index_type;

   localparam logic [STEP_W-1:0] ROW_STEP_A_RST          = 16'd263;
   localparam logic [STEP_W-1:0] ROW_STEP_B_RST          = 16'd191;
   localparam logic [STEP_W-1:0] COL_STEP_A_RST          = 16'd61;
   localparam logic [STEP_W-1:0] COL_STEP_B_RST          = 16'd43;
   localparam logic [STEP_W-1:0] FRAME_SHIFT_STEP_A_RST  = 16'd1087;
   localparam logic [STEP_W-1:0] FRAME_COLOUR_STEP_A_RST = 16'd307;
   localparam logic [STEP_W-1:0] FRAME_SHIFT_STEP_B_RST  = 16'd901;
   localparam logic [STEP_W-1:0] FRAME_COLOUR_STEP_B_RST = 16'd215;

   typedef struct packed {
      logic [STEP_W-1:0] row_step_a;
      logic [STEP_W-1:0] row_step_b;
      logic [STEP_W-1:0] col_step_a;
      logic [STEP_W-1:0] col_step_b;
      logic [STEP_W-1:0] frame_shift_step_a;
      logic [STEP_W-1:0] frame_colour_step_a;
      logic [STEP_W-1:0] frame_shift_step_b;
      logic [STEP_W-1:0] frame_colour_step_b;
   } cfg_type;

   typedef struct packed {
      logic [STEP_W-1:0] shift_a;
      logic [STEP_W-1:0] colour_a;
      logic [STEP_W-1:0] shift_b;
      logic [STEP_W-1:0] colour_b;
   } phase_type;

   // First quarter of the wave, sin scaled by 128 and truncated.
   localparam logic [7:0] QUARTER_SINE [129] = '{
      8'd0,   8'd1,   8'd3,   8'd4,   8'd6,   8'd7,   8'd9,   8'd10,
      8'd12,  8'd14,  8'd15,  8'd17,  8'd18,  8'd20,  8'd21,  8'd23,
      8'd24,  8'd26,  8'd28,  8'd29,  8'd31,  8'd32,  8'd34,  8'd35,
      8'd37,  8'd38,  8'd40,  8'd41,  8'd43,  8'd44,  8'd46,  8'd47,
      8'd48,  8'd50,  8'd51,  8'd53,  8'd54,  8'd56,  8'd57,  8'd58,
      8'd60,  8'd61,  8'd63,  8'd64,  8'd65,  8'd67,  8'd68,  8'd69,
      8'd71,  8'd72,  8'd73,  8'd74,  8'd76,  8'd77,  8'd78,  8'd79,
      8'd81,  8'd82,  8'd83,  8'd84,  8'd85,  8'd87,  8'd88,  8'd89,
      8'd90,  8'd91,  8'd92,  8'd93,  8'd94,  8'd95,  8'd96,  8'd97,
      8'd98,  8'd99,  8'd100, 8'd101, 8'd102, 8'd103, 8'd104, 8'd105,
      8'd106, 8'd107, 8'd108, 8'd108, 8'd109, 8'd110, 8'd111, 8'd112,
      8'd112, 8'd113, 8'd114, 8'd115, 8'd115, 8'd116, 8'd117, 8'd117,
      8'd118, 8'd118, 8'd119, 8'd119, 8'd120, 8'd121, 8'd121, 8'd122,
      8'd122, 8'd122, 8'd123, 8'd123, 8'd124, 8'd124, 8'd124, 8'd125,
      8'd125, 8'd125, 8'd126, 8'd126, 8'd126, 8'd126, 8'd127, 8'd127,
      8'd127, 8'd127, 8'd127, 8'd127, 8'd127, 8'd127, 8'd127, 8'd127,
      8'd128
   };

   // Full wave from the quarter table: the second quarter mirrors the first and
   // the upper half of the address range negates.
   function automatic logic signed [SINE_W-1:0] sine_val(input logic [SINE_ADDR_W-1:0] addr);
      logic [7:0] h;
      logic [8:0] hm;
      logic [7:0] m;
      h  = addr[7:0];
      hm = 9'd256 - {1'b0, h};
      if (h <= 8'd128) begin
         m = QUARTER_SINE[h];
      end else begin
         m = QUARTER_SINE[hm[7:0]];
      end
      if (addr[8]) begin
         return -$signed({1'b0, m});
      end else begin
         return $signed({1'b0, m});
      end
   endfunction

endpackage

`default_nettype wire

[design/ippg_if.sv]
// Valid/ready channel interfaces for the plasma pixel generator: pixel requests,
// colour responses and register writes. Field widths come from ippg_pkg.
`default_nettype none

interface ippg_req_if;
   logic                        valid;
   logic                        ready;
   logic [ippg_pkg::X_W-1:0]    pixel_x;
   logic [ippg_pkg::Y_W-1:0]    pixel_y;
   logic                        frame_last;

   modport source (output valid, pixel_x, pixel_y, frame_last, input ready);
   modport sink   (input valid, pixel_x, pixel_y, frame_last, output ready);
endinterface

interface ippg_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [ippg_pkg::COLOUR_W-1:0]  pixel_colour;

   modport source (output valid, pixel_colour, input ready);
   modport sink   (input valid, pixel_colour, output ready);
endinterface

interface ippg_csr_if;
   logic                            valid;
   logic                            ready;
   logic [ippg_pkg::CSR_IDX_W-1:0]  index;
   logic [ippg_pkg::STEP_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[design/interlaced_plasma_pixel_generator.sv]
// Interlaced plasma pixel generator: a nine-stage pipeline, one pixel per clock
// while rsp is not stalled. A response is presented once its request has passed
// through every stage; a stall backs up only as far as the first empty stage.
// Throughput is one pixel per cycle while rsp is not stalled; the three multipliers
// and two sine lookups each have a stage of their own. Synchronous reset empties
// the pipeline, restores the register defaults and zeroes the frame phases.
`default_nettype none

module interlaced_plasma_pixel_generator #(
   parameter int SCREEN_HEIGHT = ippg_pkg::SCREEN_HEIGHT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   ippg_req_if.sink    req_ch,
   ippg_rsp_if.source  rsp_ch,
   ippg_csr_if.sink    csr_ch
);
   import ippg_pkg::*;

   localparam int NSTG     = 9;
   localparam int PAL_SIZE = SCREEN_HEIGHT + SHIFT_SPAN;
   localparam int PAL_HALF = PAL_SIZE / 2;
   localparam int PIDX_W   = $clog2(PAL_SIZE);
   localparam int J_W      = $clog2(PAL_HALF);
   localparam int NUM_W    = $clog2((PAL_HALF - 1) * 256 + 1);
   localparam int SHR      = NUM_W + $clog2(PAL_HALF);
   localparam int RECIP_W  = NUM_W + 2;
   // Reciprocal of the half palette size; exact for every numerator below 2**NUM_W.
   localparam longint unsigned RECIP = ((64'd1 << SHR) + PAL_HALF - 1) / PAL_HALF;

   typedef struct packed {
      logic [X_W-1:0]    x;
      logic [ROW_W-1:0]  row;
      logic              odd;
      logic [STEP_W-1:0] shift_phase;
      logic [STEP_W-1:0] colour_phase;
      logic [STEP_W-1:0] row_prod;
   } s1_type;

   typedef struct packed {
      logic [X_W-1:0]    x;
      logic [ROW_W-1:0]  row;
      logic              odd;
      logic [STEP_W-1:0] colour_phase;
      logic [SINE_W-1:0] shift;
   } s2_type;

   typedef struct packed {
      logic [ROW_W-1:0]  row;
      logic              odd;
      logic [STEP_W-1:0] colour_phase;
      logic [COL_W-1:0]  col_idx;
   } s3_type;

   typedef struct packed {
      logic [ROW_W-1:0]  row;
      logic              odd;
      logic [STEP_W-1:0] colour_phase;
      logic [STEP_W-1:0] col_prod;
   } s4_type;

   typedef struct packed {
      logic [ROW_W-1:0]  row;
      logic              odd;
      logic [SINE_W-1:0] sine;
   } s5_type;

   typedef struct packed {
      logic           odd;
      logic           mid;
      logic [J_W-1:0] ramp_pos;
   } s6_type;

   typedef struct packed {
      logic             odd;
      logic             mid;
      logic [NUM_W-1:0] num;
   } s7_type;

   typedef struct packed {
      logic              odd;
      logic              mid;
      logic [CHAN_W-1:0] level;
   } s8_type;

   cfg_type   cfg;
   phase_type phase;
   logic      req_xfer;
   logic      frame_adv;

   logic [NSTG:1] vld_ff, vld_in;
   logic [NSTG:1] adv;

   s1_type s1_ff, s1_in;
   s2_type s2_ff, s2_in;
   s3_type s3_ff, s3_in;
   s4_type s4_ff, s4_in;
   s5_type s5_ff, s5_in;
   s6_type s6_ff, s6_in;
   s7_type s7_ff, s7_in;
   s8_type s8_ff, s8_in;
   logic [COLOUR_W-1:0] colour_ff, colour_in;

   logic [STEP_W+ROW_W-1:0]     row_prod_full;
   logic [STEP_W-1:0]           row_step;
   logic [STEP_W-1:0]           shift_pos;
   logic signed [SINE_W-1:0]    sine1;
   logic [COL_W:0]              col_sum;
   logic [STEP_W+COL_W-1:0]     col_prod_full;
   logic [STEP_W-1:0]           col_step;
   logic [STEP_W-1:0]           colour_pos;
   logic [SINE_W-1:0]           pal_raw;
   logic [PIDX_W-1:0]           pal_idx;
   logic [PIDX_W-1:0]           pal_mirror;
   logic [NUM_W+RECIP_W-1:0]    recip_prod;
   logic [CHAN_W-1:0]           lvl;

   ippg_regs u_regs (
      .clock   (clock),
      .reset   (reset),
      .csr_ch  (csr_ch),
      .advance (frame_adv),
      .cfg     (cfg),
      .phase   (phase)
   );

   // A stage takes new data when it is empty or its successor moves on.
   always_comb begin
      adv[NSTG] = !vld_ff[NSTG] || rsp_ch.ready;
      for (int k = NSTG - 1; k >= 1; k--) begin
         adv[k] = !vld_ff[k] || adv[k+1];
      end
      vld_in[1] = adv[1] ? req_ch.valid : vld_ff[1];
      for (int k = 2; k <= NSTG; k++) begin
         vld_in[k] = adv[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   assign req_ch.ready = adv[1];
   assign req_xfer     = req_ch.valid && adv[1];
   // Stage one has already captured the old phases when they advance.
   assign frame_adv    = req_xfer && req_ch.frame_last;

   assign rsp_ch.valid        = vld_ff[NSTG];
   assign rsp_ch.pixel_colour = colour_ff;

   always_comb begin
      // Stage 1: row pair times the shift step.
      s1_in.x   = req_ch.pixel_x;
      s1_in.row = req_ch.pixel_y[Y_W-1:1];
      s1_in.odd = req_ch.pixel_y[0];
      row_step  = req_ch.pixel_y[0] ? cfg.row_step_b : cfg.row_step_a;
      row_prod_full      = row_step * req_ch.pixel_y[Y_W-1:1];
      s1_in.row_prod     = row_prod_full[STEP_W-1:0];
      s1_in.shift_phase  = req_ch.pixel_y[0] ? phase.shift_b : phase.shift_a;
      s1_in.colour_phase = req_ch.pixel_y[0] ? phase.colour_b : phase.colour_a;

      // Stage 2: shift phase and first sine lookup. Plasma A takes half the
      // shift, rounded toward minus infinity.
      shift_pos          = s1_ff.shift_phase + s1_ff.row_prod;
      sine1              = sine_val(shift_pos[STEP_W-1:PHASE_FRAC]);
      s2_in.x            = s1_ff.x;
      s2_in.row          = s1_ff.row;
      s2_in.odd          = s1_ff.odd;
      s2_in.colour_phase = s1_ff.colour_phase;
      s2_in.shift        = s1_ff.odd ? sine1 : {sine1[SINE_W-1], sine1[SINE_W-1:1]};

      // Stage 3: source column plus one; always positive, so modular math is exact.
      col_sum = {2'b00, s2_ff.x} + (COL_W+1)'(HALF_SPAN + 1)
                - {{(COL_W+1-SINE_W){s2_ff.shift[SINE_W-1]}}, s2_ff.shift};
      s3_in.row          = s2_ff.row;
      s3_in.odd          = s2_ff.odd;
      s3_in.colour_phase = s2_ff.colour_phase;
      s3_in.col_idx      = col_sum[COL_W-1:0];

      // Stage 4: column times the colour step.
      col_step           = s3_ff.odd ? cfg.col_step_b : cfg.col_step_a;
      col_prod_full      = col_step * s3_ff.col_idx;
      s4_in.row          = s3_ff.row;
      s4_in.odd          = s3_ff.odd;
      s4_in.colour_phase = s3_ff.colour_phase;
      s4_in.col_prod     = col_prod_full[STEP_W-1:0];

      // Stage 5: colour phase and second sine lookup.
      colour_pos = s4_ff.colour_phase + s4_ff.col_prod;
      s5_in.row  = s4_ff.row;
      s5_in.odd  = s4_ff.odd;
      s5_in.sine = sine_val(colour_pos[STEP_W-1:PHASE_FRAC]);

      // Stage 6: palette index, saturated, then folded onto the ramp.
      pal_raw = {1'b0, s5_ff.row} + SINE_W'(HALF_SPAN) - s5_ff.sine;
      if (PIDX_W'(pal_raw) > PIDX_W'(PAL_SIZE - 1)) begin
         pal_idx = PIDX_W'(PAL_SIZE - 1);
      end else begin
         pal_idx = PIDX_W'(pal_raw);
      end
      pal_mirror = PIDX_W'(PAL_SIZE - 1) - pal_idx;
      s6_in.odd  = s5_ff.odd;
      s6_in.mid  = 1'b0;
      if (pal_idx < PIDX_W'(PAL_HALF)) begin
         s6_in.ramp_pos = pal_idx[J_W-1:0];
      end else if (pal_idx >= PIDX_W'(PAL_SIZE - PAL_HALF)) begin
         s6_in.ramp_pos = pal_mirror[J_W-1:0];
      end else begin
         // Middle entry of an odd-sized palette is black.
         s6_in.ramp_pos = '0;
         s6_in.mid      = 1'b1;
      end

      // Stage 7: numerator of the rounded-up ramp division.
      s7_in.odd = s6_ff.odd;
      s7_in.mid = s6_ff.mid;
      s7_in.num = NUM_W'({s6_ff.ramp_pos, 8'b0}) - NUM_W'(s6_ff.ramp_pos)
                  + NUM_W'(PAL_HALF - 1);

      // Stage 8: divide by the half palette size through the reciprocal.
      recip_prod  = s7_ff.num * RECIP_W'(RECIP);
      s8_in.odd   = s7_ff.odd;
      s8_in.mid   = s7_ff.mid;
      s8_in.level = recip_prod[SHR +: CHAN_W];

      // Stage 9: pack the colour into the output register.
      lvl = s8_ff.level;
      if (s8_ff.mid) begin
         colour_in = '0;
      end else if (s8_ff.odd) begin
         colour_in = {1'b0, ~lvl[CHAN_W-1:1], 1'b0, lvl[CHAN_W-1:1], 2'b00, lvl[CHAN_W-1:2]};
      end else begin
         colour_in = {{(COLOUR_W-CHAN_W){1'b0}}, lvl};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[1]) s1_ff <= s1_in;
      if (adv[2]) s2_ff <= s2_in;
      if (adv[3]) s3_ff <= s3_in;
      if (adv[4]) s4_ff <= s4_in;
      if (adv[5]) s5_ff <= s5_in;
      if (adv[6]) s6_ff <= s6_in;
      if (adv[7]) s7_ff <= s7_in;
      if (adv[8]) s8_ff <= s8_in;
      if (adv[9]) colour_ff <= colour_in;
   end

endmodule

`default_nettype wire

[design/ippg_regs.sv]
// Configuration registers and the four frame phases of the plasma generator.
// Depends on ippg_pkg and the ippg_csr_if interface.
`default_nettype none

module ippg_regs (
   input  logic                clock,
   input  logic                reset,
   ippg_csr_if.sink            csr_ch,
   input  logic                advance,
   output ippg_pkg::cfg_type   cfg,
   output ippg_pkg::phase_type phase
);
   import ippg_pkg::*;

   cfg_type   cfg_ff, cfg_in;
   phase_type phase_ff, phase_in;

   assign csr_ch.ready = 1'b1;
   assign cfg          = cfg_ff;
   assign phase        = phase_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         case (reg_index_type'(csr_ch.index))
            REG_ROW_STEP_A:          cfg_in.row_step_a          = csr_ch.data;
            REG_ROW_STEP_B:          cfg_in.row_step_b          = csr_ch.data;
            REG_COL_STEP_A:          cfg_in.col_step_a          = csr_ch.data;
            REG_COL_STEP_B:          cfg_in.col_step_b          = csr_ch.data;
            REG_FRAME_SHIFT_STEP_A:  cfg_in.frame_shift_step_a  = csr_ch.data;
            REG_FRAME_COLOUR_STEP_A: cfg_in.frame_colour_step_a = csr_ch.data;
            REG_FRAME_SHIFT_STEP_B:  cfg_in.frame_shift_step_b  = csr_ch.data;
            REG_FRAME_COLOUR_STEP_B: cfg_in.frame_colour_step_b = csr_ch.data;
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end

      phase_in = phase_ff;
      if (advance) begin
         phase_in.shift_a  = phase_ff.shift_a  + cfg_ff.frame_shift_step_a;
         phase_in.colour_a = phase_ff.colour_a + cfg_ff.frame_colour_step_a;
         phase_in.shift_b  = phase_ff.shift_b  + cfg_ff.frame_shift_step_b;
         phase_in.colour_b = phase_ff.colour_b + cfg_ff.frame_colour_step_b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.row_step_a          <= ROW_STEP_A_RST;
         cfg_ff.row_step_b          <= ROW_STEP_B_RST;
         cfg_ff.col_step_a          <= COL_STEP_A_RST;
         cfg_ff.col_step_b          <= COL_STEP_B_RST;
         cfg_ff.frame_shift_step_a  <= FRAME_SHIFT_STEP_A_RST;
         cfg_ff.frame_colour_step_a <= FRAME_COLOUR_STEP_A_RST;
         cfg_ff.frame_shift_step_b  <= FRAME_SHIFT_STEP_B_RST;
         cfg_ff.frame_colour_step_b <= FRAME_COLOUR_STEP_B_RST;
         phase_ff                   <= '0;
      end else begin
         cfg_ff   <= cfg_in;
         phase_ff <= phase_in;
      end
   end

endmodule

`default_nettype wire
